### sv/hcbc_pkg.sv
// Shared widths, register indexes, reset values and types of the HSV blob centroid unit.
package hcbc_pkg;

  localparam int unsigned ChanWidth    = 8;
  localparam int unsigned RowWidth     = 9;
  localparam int unsigned ColWidth     = 10;
  localparam int unsigned SumWidth     = 28;
  localparam int unsigned CntWidth     = 19;
  localparam int unsigned CfgIdxWidth  = 4;
  localparam int unsigned CfgDataWidth = 9;

  localparam int unsigned FrameHeightDefault = 480;
  localparam int unsigned QueueDepthDefault  = 4;

  localparam logic [CntWidth-1:0] CntMax = '1;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] RegHueMin     = 4'd0;
  localparam logic [CfgIdxWidth-1:0] RegHueMax     = 4'd1;
  localparam logic [CfgIdxWidth-1:0] RegSatMin     = 4'd2;
  localparam logic [CfgIdxWidth-1:0] RegSatMax     = 4'd3;
  localparam logic [CfgIdxWidth-1:0] RegValMin     = 4'd4;
  localparam logic [CfgIdxWidth-1:0] RegValMax     = 4'd5;
  localparam logic [CfgIdxWidth-1:0] RegRowCutoff  = 4'd6;
  localparam logic [CfgIdxWidth-1:0] RegInvertMask = 4'd7;

  localparam logic [ChanWidth-1:0] HueMinReset = 8'd166;
  localparam logic [ChanWidth-1:0] HueMaxReset = 8'd179;
  localparam logic [ChanWidth-1:0] SatMinReset = 8'd101;
  localparam logic [ChanWidth-1:0] SatMaxReset = 8'd189;
  localparam logic [ChanWidth-1:0] ValMinReset = 8'd181;
  localparam logic [ChanWidth-1:0] ValMaxReset = 8'd255;

  typedef struct packed {
    logic [ChanWidth-1:0] hue_min;
    logic [ChanWidth-1:0] hue_max;
    logic [ChanWidth-1:0] sat_min;
    logic [ChanWidth-1:0] sat_max;
    logic [ChanWidth-1:0] val_min;
    logic [ChanWidth-1:0] val_max;
    logic [RowWidth-1:0]  row_cutoff;
    logic                 invert_mask;
  } cfg_t;

  // One classified item on its way from the front end to the back end.
  typedef struct packed {
    logic                mask_bit;
    logic                frame_end;
    logic [SumWidth-1:0] row_sum;
    logic [SumWidth-1:0] col_sum;
    logic [CntWidth-1:0] hit_count;
  } entry_t;

endpackage

### sv/hcbc_queue.sv
// Small register FIFO of classified items between the front end and the back end.
module hcbc_queue #(
  parameter int unsigned Depth = hcbc_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hcbc_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output hcbc_pkg::entry_t entry_o,
  output logic            empty_o
);

  localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountWidth = $clog2(Depth + 1);

  hcbc_pkg::entry_t         store_q [Depth];
  logic [PtrWidth-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CountWidth-1:0]    count_q, count_d;

  assign full_o  = (count_q == CountWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign entry_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CountWidth'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CountWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### sv/hcbc_front.sv
// Front end: configuration registers, colour window test and frame accumulators.
module hcbc_front #(
  parameter int unsigned FrameHeight = hcbc_pkg::FrameHeightDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hcbc_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [hcbc_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hcbc_pkg::ChanWidth-1:0]     hue_i,
  input  logic [hcbc_pkg::ChanWidth-1:0]     saturation_i,
  input  logic [hcbc_pkg::ChanWidth-1:0]     brightness_i,
  input  logic [hcbc_pkg::RowWidth-1:0]      pixel_row_i,
  input  logic [hcbc_pkg::ColWidth-1:0]      pixel_col_i,
  input  logic                               frame_end_i,
  output logic                               push_o,
  output hcbc_pkg::entry_t                   entry_o,
  input  logic                               full_i
);

  localparam logic [hcbc_pkg::RowWidth-1:0] RowCutoffReset =
    hcbc_pkg::RowWidth'(FrameHeight - 1);

  hcbc_pkg::cfg_t                    cfg_q, cfg_d;
  logic [hcbc_pkg::SumWidth-1:0]     row_sum_q, row_sum_d;
  logic [hcbc_pkg::SumWidth-1:0]     col_sum_q, col_sum_d;
  logic [hcbc_pkg::CntWidth-1:0]     hit_count_q, hit_count_d;
  logic [hcbc_pkg::SumWidth:0]       row_add, col_add;
  logic [hcbc_pkg::SumWidth-1:0]     row_sum_new, col_sum_new;
  logic [hcbc_pkg::CntWidth-1:0]     hit_count_new;
  logic                              hit;
  logic                              accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full_i;
  assign accept      = in_valid_i && !full_i;
  assign push_o      = accept;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        hcbc_pkg::RegHueMin:     cfg_d.hue_min     = cfg_data_i[hcbc_pkg::ChanWidth-1:0];
        hcbc_pkg::RegHueMax:     cfg_d.hue_max     = cfg_data_i[hcbc_pkg::ChanWidth-1:0];
        hcbc_pkg::RegSatMin:     cfg_d.sat_min     = cfg_data_i[hcbc_pkg::ChanWidth-1:0];
        hcbc_pkg::RegSatMax:     cfg_d.sat_max     = cfg_data_i[hcbc_pkg::ChanWidth-1:0];
        hcbc_pkg::RegValMin:     cfg_d.val_min     = cfg_data_i[hcbc_pkg::ChanWidth-1:0];
        hcbc_pkg::RegValMax:     cfg_d.val_max     = cfg_data_i[hcbc_pkg::ChanWidth-1:0];
        hcbc_pkg::RegRowCutoff:  cfg_d.row_cutoff  = cfg_data_i[hcbc_pkg::RowWidth-1:0];
        hcbc_pkg::RegInvertMask: cfg_d.invert_mask = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign hit = (hue_i >= cfg_q.hue_min) && (hue_i <= cfg_q.hue_max) &&
               (saturation_i >= cfg_q.sat_min) && (saturation_i <= cfg_q.sat_max) &&
               (brightness_i >= cfg_q.val_min) && (brightness_i <= cfg_q.val_max) &&
               (pixel_row_i <= cfg_q.row_cutoff);

  // The all-ones limit means a carry out of the sum is exactly the overflow case.
  assign row_add = {1'b0, row_sum_q} + (hcbc_pkg::SumWidth + 1)'(pixel_row_i);
  assign col_add = {1'b0, col_sum_q} + (hcbc_pkg::SumWidth + 1)'(pixel_col_i);

  always_comb begin
    row_sum_new   = row_sum_q;
    col_sum_new   = col_sum_q;
    hit_count_new = hit_count_q;
    if (hit) begin
      row_sum_new   = row_add[hcbc_pkg::SumWidth] ? '1 : row_add[hcbc_pkg::SumWidth-1:0];
      col_sum_new   = col_add[hcbc_pkg::SumWidth] ? '1 : col_add[hcbc_pkg::SumWidth-1:0];
      hit_count_new = (hit_count_q == hcbc_pkg::CntMax) ? hit_count_q
                                                        : hit_count_q + hcbc_pkg::CntWidth'(1);
    end
  end

  always_comb begin
    row_sum_d   = row_sum_q;
    col_sum_d   = col_sum_q;
    hit_count_d = hit_count_q;
    if (accept) begin
      if (frame_end_i) begin
        row_sum_d   = '0;
        col_sum_d   = '0;
        hit_count_d = '0;
      end else begin
        row_sum_d   = row_sum_new;
        col_sum_d   = col_sum_new;
        hit_count_d = hit_count_new;
      end
    end
  end

  assign entry_o.mask_bit  = hit ^ cfg_q.invert_mask;
  assign entry_o.frame_end = frame_end_i;
  assign entry_o.row_sum   = row_sum_new;
  assign entry_o.col_sum   = col_sum_new;
  assign entry_o.hit_count = hit_count_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_min     <= hcbc_pkg::HueMinReset;
      cfg_q.hue_max     <= hcbc_pkg::HueMaxReset;
      cfg_q.sat_min     <= hcbc_pkg::SatMinReset;
      cfg_q.sat_max     <= hcbc_pkg::SatMaxReset;
      cfg_q.val_min     <= hcbc_pkg::ValMinReset;
      cfg_q.val_max     <= hcbc_pkg::ValMaxReset;
      cfg_q.row_cutoff  <= RowCutoffReset;
      cfg_q.invert_mask <= 1'b0;
      row_sum_q         <= '0;
      col_sum_q         <= '0;
      hit_count_q       <= '0;
    end else begin
      cfg_q       <= cfg_d;
      row_sum_q   <= row_sum_d;
      col_sum_q   <= col_sum_d;
      hit_count_q <= hit_count_d;
    end
  end

endmodule

### sv/hcbc_back.sv
// Back end: centroid division, result formatting and the output register.
module hcbc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  hcbc_pkg::entry_t               entry_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           mask_bit_o,
  output logic                           centroid_valid_o,
  output logic [hcbc_pkg::RowWidth-1:0]  centroid_row_o,
  output logic [hcbc_pkg::ColWidth-1:0]  centroid_col_o,
  output logic [hcbc_pkg::CntWidth-1:0]  match_count_o
);

  localparam int unsigned SumW  = hcbc_pkg::SumWidth;
  localparam int unsigned CntW  = hcbc_pkg::CntWidth;
  localparam int unsigned RowW  = hcbc_pkg::RowWidth;
  localparam int unsigned ColW  = hcbc_pkg::ColWidth;
  localparam int unsigned RemW  = CntW + 1;
  localparam int unsigned StepW = $clog2(SumW);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [SumW-1:0]   dvd_row_q, dvd_row_d, dvd_col_q, dvd_col_d;
  logic [SumW-1:0]   quo_row_q, quo_row_d, quo_col_q, quo_col_d;
  logic [RemW-1:0]   rem_row_q, rem_row_d, rem_col_q, rem_col_d;
  logic [CntW-1:0]   div_q, div_d;
  logic              mask_q, mask_d;

  logic              out_valid_q, out_valid_d;
  logic              res_mask_q, res_mask_d;
  logic              res_cv_q, res_cv_d;
  logic [RowW-1:0]   res_row_q, res_row_d;
  logic [ColW-1:0]   res_col_q, res_col_d;
  logic [CntW-1:0]   res_cnt_q, res_cnt_d;

  logic              out_free;
  logic              load_out;
  logic [RemW-1:0]   row_shift, col_shift;
  logic              row_ge, col_ge;

  assign out_free = !out_valid_q || !out_stall_i;

  // One restoring division step per cycle on each coordinate, sharing the divisor.
  assign row_shift = {rem_row_q[RemW-2:0], dvd_row_q[SumW-1]};
  assign col_shift = {rem_col_q[RemW-2:0], dvd_col_q[SumW-1]};
  assign row_ge    = row_shift >= {1'b0, div_q};
  assign col_ge    = col_shift >= {1'b0, div_q};

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    dvd_row_d  = dvd_row_q;
    dvd_col_d  = dvd_col_q;
    quo_row_d  = quo_row_q;
    quo_col_d  = quo_col_q;
    rem_row_d  = rem_row_q;
    rem_col_d  = rem_col_q;
    div_d      = div_q;
    mask_d     = mask_q;
    pop_o      = 1'b0;
    load_out   = 1'b0;
    res_mask_d = res_mask_q;
    res_cv_d   = res_cv_q;
    res_row_d  = res_row_q;
    res_col_d  = res_col_q;
    res_cnt_d  = res_cnt_q;

    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          if (entry_i.frame_end && (entry_i.hit_count != '0)) begin
            pop_o     = 1'b1;
            dvd_row_d = entry_i.row_sum;
            dvd_col_d = entry_i.col_sum;
            rem_row_d = '0;
            rem_col_d = '0;
            quo_row_d = '0;
            quo_col_d = '0;
            div_d     = entry_i.hit_count;
            mask_d    = entry_i.mask_bit;
            step_d    = StepW'(SumW - 1);
            state_d   = StDiv;
          end else if (out_free) begin
            // Plain pixels and empty frames need no division.
            pop_o      = 1'b1;
            load_out   = 1'b1;
            res_mask_d = entry_i.mask_bit;
            res_cv_d   = entry_i.frame_end;
            res_row_d  = '0;
            res_col_d  = '0;
            res_cnt_d  = '0;
          end
        end
      end
      StDiv: begin
        dvd_row_d = {dvd_row_q[SumW-2:0], 1'b0};
        dvd_col_d = {dvd_col_q[SumW-2:0], 1'b0};
        rem_row_d = row_ge ? row_shift - {1'b0, div_q} : row_shift;
        rem_col_d = col_ge ? col_shift - {1'b0, div_q} : col_shift;
        quo_row_d = {quo_row_q[SumW-2:0], row_ge};
        quo_col_d = {quo_col_q[SumW-2:0], col_ge};
        step_d    = step_q - StepW'(1);
        if (step_q == '0) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          load_out   = 1'b1;
          res_mask_d = mask_q;
          res_cv_d   = 1'b1;
          res_row_d  = (|quo_row_q[SumW-1:RowW]) ? '1 : quo_row_q[RowW-1:0];
          res_col_d  = (|quo_col_q[SumW-1:ColW]) ? '1 : quo_col_q[ColW-1:0];
          res_cnt_d  = div_q;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    dvd_row_q  <= dvd_row_d;
    dvd_col_q  <= dvd_col_d;
    quo_row_q  <= quo_row_d;
    quo_col_q  <= quo_col_d;
    rem_row_q  <= rem_row_d;
    rem_col_q  <= rem_col_d;
    div_q      <= div_d;
    mask_q     <= mask_d;
    res_mask_q <= res_mask_d;
    res_cv_q   <= res_cv_d;
    res_row_q  <= res_row_d;
    res_col_q  <= res_col_d;
    res_cnt_q  <= res_cnt_d;
  end

  assign out_valid_o      = out_valid_q;
  assign mask_bit_o       = res_mask_q;
  assign centroid_valid_o = res_cv_q;
  assign centroid_row_o   = res_row_q;
  assign centroid_col_o   = res_col_q;
  assign match_count_o    = res_cnt_q;

endmodule

### sv/hsv_color_blob_centroid_unit.sv
// Top level of the HSV colour window detector with blob centroid.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+------------------------------------------
//   cfg     | in        | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i, in_stall_o   | hue, saturation, brightness, row, col, end
//   out     | out       | out_valid_o, out_stall_i | mask_bit, centroid valid/row/col, count
//
// Ordinary pixels pass at one item per cycle when the back end is not dividing and the output
// is not stalled, through the queue and the output register. A frame-end item with at least
// one match holds the back end while the bit-per-cycle restoring divider runs; the queue of
// QueueDepth items lets the front end keep accepting meanwhile, and it stalls only once the
// queue is full. Reset is asynchronous and restores the register defaults and clears the
// accumulators; there is no clearing pass. Configuration writes are always ready.
module hsv_color_blob_centroid_unit #(
  parameter int unsigned FrameHeight = hcbc_pkg::FrameHeightDefault,
  parameter int unsigned QueueDepth  = hcbc_pkg::QueueDepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hcbc_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [hcbc_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [hcbc_pkg::ChanWidth-1:0]     hue_i,
  input  logic [hcbc_pkg::ChanWidth-1:0]     saturation_i,
  input  logic [hcbc_pkg::ChanWidth-1:0]     brightness_i,
  input  logic [hcbc_pkg::RowWidth-1:0]      pixel_row_i,
  input  logic [hcbc_pkg::ColWidth-1:0]      pixel_col_i,
  input  logic                               frame_end_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               mask_bit_o,
  output logic                               centroid_valid_o,
  output logic [hcbc_pkg::RowWidth-1:0]      centroid_row_o,
  output logic [hcbc_pkg::ColWidth-1:0]      centroid_col_o,
  output logic [hcbc_pkg::CntWidth-1:0]      match_count_o
);

  hcbc_pkg::entry_t push_entry;
  hcbc_pkg::entry_t pop_entry;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  hcbc_front #(
    .FrameHeight (FrameHeight)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .pixel_row_i  (pixel_row_i),
    .pixel_col_i  (pixel_col_i),
    .frame_end_i  (frame_end_i),
    .push_o       (push),
    .entry_o      (push_entry),
    .full_i       (full)
  );

  hcbc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  hcbc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .entry_i          (pop_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mask_bit_o       (mask_bit_o),
    .centroid_valid_o (centroid_valid_o),
    .centroid_row_o   (centroid_row_o),
    .centroid_col_o   (centroid_col_o),
    .match_count_o    (match_count_o)
  );

endmodule

### sv/hcbc_checker.sv
// Port-level assertions for the blob centroid unit, bound to its top level.
module hcbc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              mask_bit_o,
  input logic                              centroid_valid_o,
  input logic [hcbc_pkg::RowWidth-1:0]     centroid_row_o,
  input logic [hcbc_pkg::ColWidth-1:0]     centroid_col_o,
  input logic [hcbc_pkg::CntWidth-1:0]     match_count_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mask_bit_o) && $stable(centroid_valid_o) &&
      $stable(centroid_row_o) && $stable(centroid_col_o) && $stable(match_count_o))
    else $error("result payload changed while stalled");

  // Only a frame-end result carries centroid data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !centroid_valid_o |->
      centroid_row_o == '0 && centroid_col_o == '0 && match_count_o == '0)
    else $error("centroid fields set on an ordinary pixel");

  // A frame without matches reports the origin as its centroid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && centroid_valid_o && match_count_o == '0 |->
      centroid_row_o == '0 && centroid_col_o == '0)
    else $error("non-zero centroid for an empty frame");

endmodule

bind hsv_color_blob_centroid_unit hcbc_checker u_hcbc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .mask_bit_o       (mask_bit_o),
  .centroid_valid_o (centroid_valid_o),
  .centroid_row_o   (centroid_row_o),
  .centroid_col_o   (centroid_col_o),
  .match_count_o    (match_count_o)
);
